// ----- rtl/core/pcsma_pkg.sv -----
// ----------------------------------------------------------------------------
// pcsma_pkg
// Shared types and constants for the p-persistent channel access controller.
// ----------------------------------------------------------------------------
package pcsma_pkg;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned RND_W    = 8;
    localparam int unsigned MUTE_W   = 17;
    localparam int unsigned DEFER_W  = 17;
    localparam int unsigned SLOT_W   = 8;
    localparam int unsigned KEYUP_W  = 16;
    localparam int unsigned PCODE_W  = 3;
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 24;

    // extra holdoff after a frame, in ms
    localparam logic [DEFER_W-1:0] HOLDOFF_EXTRA_MS = 17'd500;

    // register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_PERSISTENCE = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_KEYUP_MS    = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_SLOT_MS     = 4'h8;

    // register reset values
    localparam logic [7:0]  RST_PERSISTENCE = 8'd64;
    localparam logic [15:0] RST_KEYUP_MS    = 16'd15;
    localparam logic [7:0]  RST_SLOT_MS     = 8'd55;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_REQUEST    = 2'd1,
        OP_MUTE       = 2'd2,
        OP_FRAME_DONE = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_DEFER = 5'b00010,
        PH_SLOT  = 5'b00100,
        PH_KEYUP = 5'b01000,
        PH_TX    = 5'b10000
    } t_phase;

    // external phase codes
    localparam logic [PCODE_W-1:0] PCODE_IDLE  = 3'd0;
    localparam logic [PCODE_W-1:0] PCODE_DEFER = 3'd1;
    localparam logic [PCODE_W-1:0] PCODE_SLOT  = 3'd2;
    localparam logic [PCODE_W-1:0] PCODE_KEYUP = 3'd3;
    localparam logic [PCODE_W-1:0] PCODE_TX    = 3'd4;

    typedef struct packed {
        logic [7:0]         persistence;
        logic [KEYUP_W-1:0] keyup_ms;
        logic [SLOT_W-1:0]  slot_ms;
    } t_cfg;

    typedef struct packed {
        logic [PCODE_W-1:0] phase;
        logic [DEFER_W-1:0] defer_remaining;
        logic               grant;
        logic               keyed;
    } t_result;

endpackage

// ----- rtl/core/p_persistent_channel_access_top.sv -----
// ----------------------------------------------------------------------------
// p_persistent_channel_access_top
// p-persistent CSMA channel access controller with stream ports and APB.
// ----------------------------------------------------------------------------
// One event per input transfer (1 ms tick with random byte, transmit request,
// mute, frame done); every event gives exactly one result transfer carrying
// keyed, grant, the remaining deferral and the phase after the event. The
// block takes one transfer per clock while the sink does not stall: an input
// register feeds the state update, and the result lands in an output
// register, so throughput is set only by the downstream tready. A result
// held by a stalled sink does not stop the input register from filling.
// Registers: persistence at 0x0, keyup_ms at 0x4, slot_ms at 0x8; write
// them only while no event is in flight. Counters saturate at zero.
// ----------------------------------------------------------------------------
module p_persistent_channel_access_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [1:0] op, [9:2] random_byte, [26:10] mute_ms (signed), [31:27] zero
    input  logic [pcsma_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [0] keyed, [1] grant, [18:2] defer_remaining, [21:19] phase, [23:22] zero
    output logic [pcsma_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcsma_pkg::PADDR_W-1:0]     paddr,
    input  logic [pcsma_pkg::PDATA_W-1:0]     pwdata,
    output logic [pcsma_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);

    pcsma_pkg::t_cfg    cfg;
    pcsma_pkg::t_result result;

    // input register
    logic                               r_in_valid;
    logic [pcsma_pkg::OP_W-1:0]         r_in_op;
    logic [pcsma_pkg::RND_W-1:0]        r_in_rnd;
    logic [pcsma_pkg::MUTE_W-1:0]       r_in_mute;
    // result register
    logic                               r_out_valid;
    logic [pcsma_pkg::M_TDATA_W-1:0]    r_out_data;

    logic s_fire;
    logic out_free;
    logic step;

    assign out_free   = ~r_out_valid | i_m_tready;
    assign step       = r_in_valid & out_free;
    assign o_s_tready = ~r_in_valid | out_free;
    assign s_fire     = i_s_tvalid & o_s_tready;

    pcsma_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pcsma_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_op          (r_in_op),
        .i_random_byte (r_in_rnd),
        .i_mute_ms     (r_in_mute),
        .i_cfg         (cfg),
        .o_result      (result)
    );

    // input register: refilled whenever it is empty or draining this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_fire) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_op   <= i_s_tdata[1:0];
            r_in_rnd  <= i_s_tdata[9:2];
            r_in_mute <= i_s_tdata[26:10];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= {2'b00, result.phase, result.defer_remaining,
                           result.grant, result.keyed};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // grant only ever comes with the carrier keyed and the transmit phase
    a_grant_keyed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1] |-> o_m_tdata[0] && (o_m_tdata[21:19] == pcsma_pkg::PCODE_TX))
        else $error("grant without keyed transmit phase");

    // keyed exactly in keyup or transmit phase
    a_keyed_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[0] == ((o_m_tdata[21:19] == pcsma_pkg::PCODE_KEYUP) ||
                                         (o_m_tdata[21:19] == pcsma_pkg::PCODE_TX))))
        else $error("keyed flag disagrees with phase");

    // the engine steps only when the result register can take the result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |-> !step)
        else $error("pending result overwritten");

    // a held input item is not lost while the sink stalls
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_in_op))
        else $error("input item dropped during stall");

endmodule

// ----- rtl/core/pcsma_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pcsma_cfg_regs
// APB register file: persistence, keyup delay and slot time.
// ----------------------------------------------------------------------------
module pcsma_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcsma_pkg::PADDR_W-1:0]  paddr,
    input  logic [pcsma_pkg::PDATA_W-1:0]  pwdata,
    output logic [pcsma_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready,
    output pcsma_pkg::t_cfg                o_cfg
);

    pcsma_pkg::t_cfg r_cfg;
    logic            wr_en;
    logic [pcsma_pkg::PADDR_W-1:0] addr_w;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    // word aligned decode
    assign addr_w = {paddr[pcsma_pkg::PADDR_W-1:2], 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.persistence <= pcsma_pkg::RST_PERSISTENCE;
            r_cfg.keyup_ms    <= pcsma_pkg::RST_KEYUP_MS;
            r_cfg.slot_ms     <= pcsma_pkg::RST_SLOT_MS;
        end else if (wr_en) begin
            unique case (addr_w)
                pcsma_pkg::ADDR_PERSISTENCE: r_cfg.persistence <= pwdata[7:0];
                pcsma_pkg::ADDR_KEYUP_MS:    r_cfg.keyup_ms    <= pwdata[15:0];
                pcsma_pkg::ADDR_SLOT_MS:     r_cfg.slot_ms     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (addr_w)
            pcsma_pkg::ADDR_PERSISTENCE: prdata = {24'd0, r_cfg.persistence};
            pcsma_pkg::ADDR_KEYUP_MS:    prdata = {16'd0, r_cfg.keyup_ms};
            pcsma_pkg::ADDR_SLOT_MS:     prdata = {24'd0, r_cfg.slot_ms};
            default:                     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/pcsma_engine.sv -----
// ----------------------------------------------------------------------------
// pcsma_engine
// Channel access state and counters; one event applied per step.
// ----------------------------------------------------------------------------
module pcsma_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic [pcsma_pkg::OP_W-1:0]       i_op,
    input  logic [pcsma_pkg::RND_W-1:0]      i_random_byte,
    input  logic [pcsma_pkg::MUTE_W-1:0]     i_mute_ms,
    input  pcsma_pkg::t_cfg                  i_cfg,
    output pcsma_pkg::t_result               o_result
);

    pcsma_pkg::t_phase r_phase, n_phase;
    logic [pcsma_pkg::DEFER_W-1:0] r_defer, n_defer;
    logic [pcsma_pkg::SLOT_W-1:0]  r_slot,  n_slot;
    logic [pcsma_pkg::KEYUP_W-1:0] r_keyup, n_keyup;

    logic [pcsma_pkg::DEFER_W-1:0] defer_dec;
    logic [pcsma_pkg::SLOT_W-1:0]  slot_dec;
    logic [pcsma_pkg::KEYUP_W-1:0] keyup_dec;
    logic [pcsma_pkg::DEFER_W-1:0] holdoff;
    logic                          roll_ok;
    logic                          contend;
    pcsma_pkg::t_phase             won_phase;

    assign defer_dec = (r_defer != '0) ? r_defer - 17'd1 : '0;
    assign slot_dec  = (r_slot  != '0) ? r_slot  - 8'd1  : '0;
    assign keyup_dec = (r_keyup != '0) ? r_keyup - 16'd1 : '0;
    // keyup_ms + 500 never exceeds the 17-bit range
    assign holdoff   = {1'b0, i_cfg.keyup_ms} + pcsma_pkg::HOLDOFF_EXTRA_MS;
    assign roll_ok   = (i_random_byte <= i_cfg.persistence);
    assign won_phase = (i_cfg.keyup_ms == '0) ? pcsma_pkg::PH_TX : pcsma_pkg::PH_KEYUP;

    always_comb begin
        n_phase = r_phase;
        n_defer = r_defer;
        n_slot  = r_slot;
        n_keyup = r_keyup;
        contend = 1'b0;

        unique case (pcsma_pkg::t_op'(i_op))
            pcsma_pkg::OP_TICK: begin
                n_defer = defer_dec;
                unique case (r_phase)
                    pcsma_pkg::PH_DEFER: contend = 1'b1;
                    pcsma_pkg::PH_SLOT: begin
                        n_slot = slot_dec;
                        if (slot_dec == '0) begin
                            n_phase = pcsma_pkg::PH_DEFER;
                            contend = 1'b1;
                        end
                    end
                    pcsma_pkg::PH_KEYUP: begin
                        n_keyup = keyup_dec;
                        if (keyup_dec == '0) begin
                            n_phase = pcsma_pkg::PH_TX;
                        end
                    end
                    default: ;
                endcase
                // persistence roll once the deferral has run out
                if (contend && (defer_dec == '0)) begin
                    if (roll_ok) begin
                        n_keyup = i_cfg.keyup_ms;
                        n_phase = won_phase;
                    end else begin
                        n_slot  = i_cfg.slot_ms;
                        n_phase = pcsma_pkg::PH_SLOT;
                    end
                end
            end
            pcsma_pkg::OP_REQUEST: begin
                if (r_phase == pcsma_pkg::PH_IDLE) begin
                    n_phase = pcsma_pkg::PH_DEFER;
                end
            end
            pcsma_pkg::OP_MUTE: begin
                if (&i_mute_ms) begin
                    n_defer = holdoff;
                end else if (i_mute_ms[pcsma_pkg::MUTE_W-1]) begin
                    n_defer = '0;
                end else begin
                    n_defer = i_mute_ms;
                end
            end
            pcsma_pkg::OP_FRAME_DONE: begin
                if ((r_phase == pcsma_pkg::PH_KEYUP) || (r_phase == pcsma_pkg::PH_TX)) begin
                    n_phase = pcsma_pkg::PH_IDLE;
                    n_keyup = '0;
                    n_defer = holdoff;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pcsma_pkg::PH_IDLE;
            r_defer <= '0;
            r_slot  <= '0;
            r_keyup <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_defer <= n_defer;
            r_slot  <= n_slot;
            r_keyup <= n_keyup;
        end
    end

    // result reflects the state after this event
    always_comb begin
        o_result.keyed           = (n_phase == pcsma_pkg::PH_KEYUP) ||
                                   (n_phase == pcsma_pkg::PH_TX);
        o_result.grant           = (n_phase == pcsma_pkg::PH_TX);
        o_result.defer_remaining = n_defer;
        unique case (n_phase)
            pcsma_pkg::PH_DEFER: o_result.phase = pcsma_pkg::PCODE_DEFER;
            pcsma_pkg::PH_SLOT:  o_result.phase = pcsma_pkg::PCODE_SLOT;
            pcsma_pkg::PH_KEYUP: o_result.phase = pcsma_pkg::PCODE_KEYUP;
            pcsma_pkg::PH_TX:    o_result.phase = pcsma_pkg::PCODE_TX;
            default:             o_result.phase = pcsma_pkg::PCODE_IDLE;
        endcase
    end

endmodule

// ----- dv/p_persistent_channel_access_top_test.sv -----
// ----------------------------------------------------------------------------
// p_persistent_channel_access_top_test
// Self-checking bench for the p-persistent channel access controller.
// ----------------------------------------------------------------------------
// Event transfers are queued by a stimulus process and fed by a clocked
// driver that can run in random bursts. Each accepted event steps a local copy
// of the channel state and queues the status it should produce. A clocked
// monitor with its own stall pattern checks each result transfer against the
// oldest queued status. Settings change over APB only once the block has
// drained.
// ----------------------------------------------------------------------------
module p_persistent_channel_access_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pcsma_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all
    localparam int PHASE_ITEMS    = 140;   // random events per settings phase
    localparam int N_SETTINGS     = 8;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------------
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    // [1:0] op, [9:2] random_byte, [26:10] mute_ms (signed), [31:27] zero
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 i_m_tready = 1'b0;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [PADDR_W-1:0]   paddr      = '0;
    logic [PDATA_W-1:0]   pwdata     = '0;

    logic                 o_s_tready;
    logic                 o_m_tvalid;
    // [0] keyed, [1] grant, [18:2] defer_remaining, [21:19] phase, [23:22] zero
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    p_persistent_channel_access_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic [S_TDATA_W-1:0] event_q[$];      // events waiting for the driver
    t_result              status_due_q[$]; // statuses owed by the block
    int                   queued_items = 0;
    int                   results_seen = 0;
    int                   mismatches   = 0;
    int                   idle_cycles  = 0;

    // sender / receiver idling controls, changed only between phases
    bit                   src_bursty = 1'b0;
    bit                   sink_stall = 1'b0;
    int                   burst_left = 1;
    int                   gap_left   = 0;
    logic [7:0]           stall_pat  = 8'hff;
    logic [2:0]           pat_pos    = '0;

    // settings as last written
    logic [7:0]           cfg_persistence = RST_PERSISTENCE;
    logic [KEYUP_W-1:0]   cfg_keyup_ms    = RST_KEYUP_MS;
    logic [SLOT_W-1:0]    cfg_slot_ms     = RST_SLOT_MS;

    // settings used by the random phases
    logic [7:0]           set_pers[N_SETTINGS]  = '{8'd0, 8'd255, 8'd128, 8'd64,
                                                    8'd200, 8'd30, 8'd255, 8'd100};
    logic [15:0]          set_keyup[N_SETTINGS] = '{16'd0, 16'd1, 16'd3, 16'hffff,
                                                    16'd0, 16'd7, 16'd2, 16'd500};
    logic [7:0]           set_slot[N_SETTINGS]  = '{8'd1, 8'd255, 8'd0, 8'd2,
                                                    8'd5, 8'd1, 8'd3, 8'd4};

    // channel state as the block should hold it
    logic [PCODE_W-1:0]   ch_phase = PCODE_IDLE;
    logic [DEFER_W-1:0]   ch_defer = '0;
    logic [SLOT_W-1:0]    ch_slot  = '0;
    logic [KEYUP_W-1:0]   ch_keyup = '0;

    // ------------------------------------------------------------------------
    // Channel state update, one event at a time
    // ------------------------------------------------------------------------
    // keyup_ms + 500 tops out at 66035, well inside the 17-bit counter
    function automatic logic [DEFER_W-1:0] holdoff_ms();
        return DEFER_W'(cfg_keyup_ms) + HOLDOFF_EXTRA_MS;
    endfunction

    // persistence roll, only once the deferral has run out
    function automatic void contend(input logic [7:0] rnd);
        if (ch_defer != '0) return;
        if (rnd <= cfg_persistence) begin
            ch_keyup = cfg_keyup_ms;
            ch_phase = (cfg_keyup_ms == '0) ? PCODE_TX : PCODE_KEYUP;
        end else begin
            ch_slot  = cfg_slot_ms;
            ch_phase = PCODE_SLOT;
        end
    endfunction

    function automatic void advance_channel(input logic [S_TDATA_W-1:0] d);
        logic [RND_W-1:0]  rnd;
        logic [MUTE_W-1:0] mraw;
        t_result           st;
        rnd  = d[OP_W +: RND_W];
        mraw = d[OP_W+RND_W +: MUTE_W];
        case (t_op'(d[OP_W-1:0]))
            OP_TICK: begin
                // deferral drains on every tick whatever the phase
                if (ch_defer != '0) ch_defer = ch_defer - 1'b1;
                case (ch_phase)
                    PCODE_DEFER: contend(rnd);
                    PCODE_SLOT: begin
                        if (ch_slot != '0) ch_slot = ch_slot - 1'b1;
                        // slot over: back to deferring, roll on this tick
                        if (ch_slot == '0) begin
                            ch_phase = PCODE_DEFER;
                            contend(rnd);
                        end
                    end
                    PCODE_KEYUP: begin
                        if (ch_keyup != '0) ch_keyup = ch_keyup - 1'b1;
                        if (ch_keyup == '0) ch_phase = PCODE_TX;
                    end
                    default: ;
                endcase
            end
            OP_REQUEST: begin
                if (ch_phase == PCODE_IDLE) ch_phase = PCODE_DEFER;
            end
            OP_MUTE: begin
                // -1 asks for the holdoff, other negatives clear
                if (&mraw)        ch_defer = holdoff_ms();
                else if (mraw[16]) ch_defer = '0;
                else              ch_defer = mraw;
            end
            default: begin
                // frame done only counts while keyed
                if (ch_phase == PCODE_KEYUP || ch_phase == PCODE_TX) begin
                    ch_phase = PCODE_IDLE;
                    ch_keyup = '0;
                    ch_defer = holdoff_ms();
                end
            end
        endcase
        st.keyed           = (ch_phase == PCODE_KEYUP || ch_phase == PCODE_TX);
        st.grant           = (ch_phase == PCODE_TX);
        st.defer_remaining = ch_defer;
        st.phase           = ch_phase;
        status_due_q.push_back(st);
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------------
    function automatic void log_mismatch(input string msg);
        if (mismatches < 10) $display("ERROR: %s", msg);
        mismatches++;
    endfunction

    function automatic void check_status(input logic [M_TDATA_W-1:0] d);
        t_result got;
        t_result want;
        got = d[$bits(t_result)-1:0];
        if (status_due_q.size() == 0) begin
            log_mismatch($sformatf("result %0d arrived with none due: %h",
                                   results_seen, d));
        end else begin
            want = status_due_q.pop_front();
            if (got.keyed !== want.keyed || got.grant !== want.grant ||
                got.defer_remaining !== want.defer_remaining ||
                got.phase !== want.phase) begin
                log_mismatch($sformatf({"result %0d: expected keyed %b grant %b",
                    " defer %0d phase %0d, got keyed %b grant %b defer %0d phase %0d"},
                    results_seen, want.keyed, want.grant, want.defer_remaining,
                    want.phase, got.keyed, got.grant, got.defer_remaining, got.phase));
            end
        end
        results_seen++;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: pops the event queue, bursts and gaps when src_bursty is set
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                advance_channel(i_s_tdata);
            end
            // move on once the current transfer has gone (or none held)
            if (!i_s_tvalid || o_s_tready) begin
                if (src_bursty && gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_s_tvalid <= 1'b0;
                end else if (event_q.size() != 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= event_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks result transfers, tready follows a rolling pattern
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) check_status(o_m_tdata);
            pat_pos <= pat_pos + 1'b1;
            if (pat_pos == 3'd7) stall_pat <= 8'($urandom);
            i_m_tready <= !sink_stall || stall_pat[pat_pos];
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any transfer on either stream restarts the count
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void add_event(input t_op op, input logic [RND_W-1:0] rnd,
                                      input logic [MUTE_W-1:0] mute);
        event_q.push_back(S_TDATA_W'({mute, rnd, op}));
        queued_items++;
    endfunction

    // random byte leaning on the persistence boundary
    function automatic logic [RND_W-1:0] roll_byte();
        case ($urandom_range(0, 3))
            0:       return cfg_persistence;
            1:       return cfg_persistence + 8'd1;
            default: return RND_W'($urandom);
        endcase
    endfunction

    // mostly a full request / contend / frame cycle, sometimes plain noise
    function automatic void add_session();
        if ($urandom_range(0, 9) < 8) begin
            // cut the holdoff left by the last frame to at most 3 ms
            add_event(OP_MUTE, RND_W'($urandom), MUTE_W'($urandom_range(0, 3)));
            add_event(OP_REQUEST, RND_W'($urandom), MUTE_W'($urandom));
            repeat ($urandom_range(1, 20)) begin
                if ($urandom_range(0, 15) == 0)
                    add_event(OP_REQUEST, RND_W'($urandom), MUTE_W'($urandom));
                add_event(OP_TICK, roll_byte(), MUTE_W'($urandom));
            end
            add_event(OP_FRAME_DONE, RND_W'($urandom), MUTE_W'($urandom));
        end else begin
            repeat ($urandom_range(1, 6)) begin
                add_event(t_op'($urandom_range(0, 3)), roll_byte(),
                          ($urandom_range(0, 3) == 0) ? '1 : MUTE_W'($urandom));
            end
        end
    endfunction

    task automatic write_reg(input logic [PADDR_W-1:0] addr,
                             input logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] pers, input logic [15:0] keyup,
                                  input logic [7:0] slot);
        write_reg(ADDR_PERSISTENCE, PDATA_W'(pers));
        write_reg(ADDR_KEYUP_MS, PDATA_W'(keyup));
        write_reg(ADDR_SLOT_MS, PDATA_W'(slot));
        cfg_persistence = pers;
        cfg_keyup_ms    = keyup;
        cfg_slot_ms     = slot;
    endtask

    // all events sent and every status back, plus the two-stage pipe
    task automatic wait_drained();
        while (event_q.size() != 0 || i_s_tvalid || status_due_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int          phase_start;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings: mute encodings and ignored events
        @(negedge i_clk);
        add_event(OP_TICK, 8'h00, '0);            // tick while idle
        add_event(OP_FRAME_DONE, 8'hff, '1);      // frame done, not keyed
        add_event(OP_MUTE, 8'h00, 17'h1ffff);     // -1: holdoff
        add_event(OP_MUTE, 8'h00, 17'h1fffe);     // other negative: clear
        add_event(OP_MUTE, 8'hff, 17'h10000);     // most negative
        add_event(OP_MUTE, 8'h00, 17'h0ffff);     // largest positive
        add_event(OP_REQUEST, 8'h00, '0);         // idle -> deferring
        add_event(OP_REQUEST, 8'hff, '1);         // repeat request ignored
        add_event(OP_TICK, 8'h00, '0);            // deferral not done, no roll
        add_event(OP_MUTE, 8'h00, '0);
        add_event(OP_MUTE, 8'h00, 17'd3);
        wait_drained();

        // directed, short timings: failed roll, slot, keyup, grant, frame done
        apply_settings(8'd64, 16'd1, 8'd1);
        @(negedge i_clk);
        add_event(OP_TICK, 8'h00, '0);
        add_event(OP_TICK, 8'h00, '0);
        add_event(OP_TICK, 8'hff, '0);            // roll fails -> slot wait
        add_event(OP_FRAME_DONE, 8'h00, '0);      // not keyed, ignored
        add_event(OP_TICK, 8'd64, '0);            // slot over, roll on boundary
        add_event(OP_REQUEST, 8'h00, '0);         // busy, ignored
        add_event(OP_TICK, 8'h00, '0);            // keyup done -> transmitting
        add_event(OP_TICK, 8'h55, 17'h0aaaa);
        add_event(OP_FRAME_DONE, 8'haa, 17'h15555); // unkey, holdoff
        add_event(OP_MUTE, 8'h00, '0);
        wait_drained();

        // random phases over a spread of settings
        for (int s = 0; s < N_SETTINGS; s++) begin
            apply_settings(set_pers[s], set_keyup[s], set_slot[s]);
            @(negedge i_clk);
            src_bursty  = ($urandom_range(0, 3) != 0);
            sink_stall  = ($urandom_range(0, 3) != 0);
            phase_start = queued_items;
            while (queued_items - phase_start < PHASE_ITEMS) add_session();
            wait_drained();
        end

        if (status_due_q.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", status_due_q.size()));
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
